// ----- hw/rtl/kdar_pkg.sv -----
// ============================================================================
// kdar_pkg
// Shared constants and types for the key debounce and autorepeat block:
// default sizes, per-key mode codes, event codes, operation codes and
// configuration register indexes.
// ============================================================================
package kdar_pkg;

    localparam int KEY_COUNT_DEF    = 16;
    localparam int HISTORY_BITS_DEF = 4;

    localparam int KEY_W   = 4;
    localparam int CNT_W   = 8;
    localparam int MODE_W  = 7;
    localparam int EVENT_W = 3;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [EVENT_W-1:0] event_t;
    typedef logic [OP_W-1:0]    op_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam mode_t MODE_OFF    = 7'd0;
    localparam mode_t MODE_DELAY  = 7'd95;
    localparam mode_t MODE_START  = 7'd97;
    localparam mode_t MODE_PAUSE  = 7'd98;
    localparam mode_t MODE_KILLED = 7'd99;
    localparam mode_t MODE_P16    = 7'd16;
    localparam mode_t MODE_P8     = 7'd8;
    localparam mode_t MODE_P4     = 7'd4;
    localparam mode_t MODE_P2     = 7'd2;
    localparam mode_t MODE_P1     = 7'd1;

    localparam event_t EV_NONE    = 3'd0;
    localparam event_t EV_FIRST   = 3'd1;
    localparam event_t EV_REPEAT  = 3'd2;
    localparam event_t EV_LONG    = 3'd3;
    localparam event_t EV_RELEASE = 3'd4;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_PAUSE = 2'd1;
    localparam op_t OP_KILL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE       = 2'd3;

    localparam count_t LONG_PRESS_RST  = 8'd32;
    localparam count_t FIRST_DELAY_RST = 8'd40;
    localparam count_t RATE_STEP_RST   = 8'd48;
    localparam count_t PAUSE_RST       = 8'd64;

endpackage

// ----- hw/rtl/kdar_ram.sv -----
// ============================================================================
// kdar_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module kdar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/key_debounce_autorepeat_top.sv -----
// ============================================================================
// key_debounce_autorepeat_top
// Per-key debouncer and event generator with an accelerating autorepeat
// ladder. Each request for a key in range updates that key's history, counter and mode.
// ============================================================================
//  Channel  Direction  Fields (lowest bit up)
//  s_       in         tdata: key_index[3:0], level[4]; tuser: op[1:0]
//  m_       out        tdata: key_id[3:0], event_res[6:4], pressed[7]
//  cfg_     in         cfg_index selects the register, cfg_wdata is its value
//
// One request is accepted per cycle unless the result side stalls. Each
// result passes the work stage, fed by the registered key state RAM read,
// then the result register. Back-to-back requests to the same key are
// served by a forwarding register. Reset clears the per-key valid bits, so
// every key reads as all zero. A result-side stall holds the whole pipeline.
// ============================================================================
module key_debounce_autorepeat_top
    import kdar_pkg::*;
#(
    parameter int KEY_COUNT    = KEY_COUNT_DEF,
    parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // key_index[3:0], level[4]
    input  logic [OP_W-1:0]      s_tuser,   // op[1:0]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // key_id[3:0], event_res[6:4], pressed[7]

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int ADDR_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int ENTRY_W = HISTORY_BITS + CNT_W + MODE_W;

    // Configuration registers.
    count_t long_press_reg;
    count_t first_delay_reg;
    count_t rate_step_reg;
    count_t pause_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg  <= LONG_PRESS_RST;
            first_delay_reg <= FIRST_DELAY_RST;
            rate_step_reg   <= RATE_STEP_RST;
            pause_reg       <= PAUSE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LONG_PRESS:  long_press_reg  <= cfg_wdata;
                CFG_FIRST_DELAY: first_delay_reg <= cfg_wdata;
                CFG_RATE_STEP:   rate_step_reg   <= cfg_wdata;
                CFG_PAUSE:       pause_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input decode.
    logic [KEY_W-1:0]  s_key;
    logic              s_level;
    logic [ADDR_W-1:0] s_addr;
    logic              s_in_range;
    logic              s_accept;

    assign s_key      = s_tdata[KEY_W-1:0];
    assign s_level    = s_tdata[KEY_W];
    assign s_addr     = ADDR_W'(s_key);
    assign s_in_range = (32'(s_key) < KEY_COUNT);
    assign s_accept   = s_tvalid && s_tready;

    // Work stage registers.
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_level_reg;
    logic              s1_in_range_reg;
    logic              s1_entry_valid_reg;
    logic              fwd_hit_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [KEY_COUNT-1:0] key_valid_reg;

    logic               s1_adv;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] ram_rdata;

    assign s1_adv   = s1_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign wr_en    = s1_adv && s1_in_range_reg;

    kdar_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (s_accept && s_in_range),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            key_valid_reg <= '0;
        end else begin
            if (wr_en) begin
                key_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && s_in_range && (s1_addr_reg == s_addr);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg          <= s_tuser;
            s1_key_reg         <= s_key;
            s1_addr_reg        <= s_addr;
            s1_level_reg       <= s_level;
            s1_in_range_reg    <= s_in_range;
            s1_entry_valid_reg <= s_in_range && key_valid_reg[s_addr];
            fwd_data_reg       <= wr_data;
        end
    end

    // Current state of the addressed key.
    logic [ENTRY_W-1:0]      cur_entry;
    logic [HISTORY_BITS-1:0] cur_hist;
    count_t                  cur_cnt;
    mode_t                   cur_mode;

    assign cur_entry = fwd_hit_reg ? fwd_data_reg
                                   : (s1_entry_valid_reg ? ram_rdata : '0);
    assign cur_hist  = cur_entry[HISTORY_BITS-1:0];
    assign cur_cnt   = cur_entry[HISTORY_BITS +: CNT_W];
    assign cur_mode  = cur_entry[HISTORY_BITS+CNT_W +: MODE_W];

    // Per-key update.
    logic [HISTORY_BITS-1:0] tick_hist;
    count_t                  tick_cnt;
    mode_t                   tick_mode;
    event_t                  tick_ev;
    logic [HISTORY_BITS-1:0] nxt_hist;
    count_t                  nxt_cnt;
    mode_t                   nxt_mode;
    event_t                  nxt_ev;
    logic                    nxt_pressed;

    always_comb begin
        tick_hist = {cur_hist[HISTORY_BITS-2:0], s1_level_reg};
        tick_cnt  = cur_cnt + 8'd1;
        tick_mode = cur_mode;
        tick_ev   = EV_NONE;

        if (tick_mode != MODE_OFF && tick_hist == '0) begin
            if (tick_mode != MODE_KILLED) begin
                tick_ev = EV_RELEASE;
            end
            tick_cnt  = '0;
            tick_mode = MODE_OFF;
        end

        case (tick_mode) inside
            MODE_OFF: begin
                if (tick_hist == {HISTORY_BITS{1'b1}}) begin
                    tick_mode = MODE_START;
                    tick_cnt  = '0;
                end
            end
            MODE_START: begin
                tick_ev   = EV_FIRST;
                tick_mode = MODE_DELAY;
                tick_cnt  = '0;
            end
            MODE_DELAY: begin
                if (tick_cnt == long_press_reg) begin
                    tick_ev = EV_LONG;
                end
                if (tick_cnt == first_delay_reg) begin
                    tick_mode = MODE_P16;
                    tick_cnt  = '0;
                end
            end
            MODE_P16, MODE_P8, MODE_P4, MODE_P2, MODE_P1: begin
                if (tick_mode != MODE_P1 && tick_cnt >= rate_step_reg) begin
                    tick_mode = tick_mode >> 1;
                    tick_cnt  = '0;
                end
                if ((tick_cnt & {1'b0, tick_mode - 7'd1}) == '0) begin
                    tick_ev = EV_REPEAT;
                end
            end
            MODE_PAUSE: begin
                if (tick_cnt >= pause_reg) begin
                    tick_mode = MODE_P8;
                    tick_cnt  = '0;
                end
            end
            default: ;
        endcase

        nxt_hist = cur_hist;
        nxt_cnt  = cur_cnt;
        nxt_mode = cur_mode;
        nxt_ev   = EV_NONE;
        case (s1_op_reg)
            OP_TICK: begin
                nxt_hist = tick_hist;
                nxt_cnt  = tick_cnt;
                nxt_mode = tick_mode;
                nxt_ev   = tick_ev;
            end
            OP_PAUSE: begin
                nxt_mode = MODE_PAUSE;
                nxt_cnt  = '0;
            end
            OP_KILL: begin
                nxt_mode = MODE_KILLED;
            end
            default: ;
        endcase

        if (!s1_in_range_reg) begin
            nxt_ev = EV_NONE;
        end
        nxt_pressed = s1_in_range_reg && (nxt_hist == {HISTORY_BITS{1'b1}});
    end

    assign wr_data = {nxt_mode, nxt_cnt, nxt_hist};

    // Result register.
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {nxt_pressed, nxt_ev, s1_key_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks.
    a_adv_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_tvalid)
        else $error("work stage advanced without loading a result");

    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward hit without an item in the work stage");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:4] <= EV_RELEASE))
        else $error("result carries an undefined event code");

    a_release_unpressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:4] == EV_RELEASE) |-> !m_tdata[7])
        else $error("release event while the key reads pressed");

    a_no_write_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_tvalid && !m_tready |-> !wr_en)
        else $error("state written while the result side stalls");

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for key_debounce_autorepeat_top. Requests are
// queued by a sequencer, driven onto the s_ channel with random gaps, and
// predicted per key in the testbench. Results on the m_ channel are checked
// field by field against the queue of predicted key events while the
// receiver stalls at random. The run goes through a directed opening and
// several register settings, from all ones and all zeros to all 255.
// ============================================================================
module tb;
    import kdar_pkg::*;

    localparam op_t OP_SPARE  = 2'd3;
    localparam int  HB        = HISTORY_BITS_DEF;
    localparam int  PHASES    = 6;
    localparam int  PHASE_REQ = 233;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  TAIL_CYCLES = 10;
    localparam logic [HB-1:0] HIST_FULL = '1;

    typedef struct {
        op_t             op;
        logic [KEY_W-1:0] key;
        logic            level;
    } key_req_t;

    typedef struct {
        logic [KEY_W-1:0] key_id;
        event_t          event_res;
        logic            pressed;
    } key_result_t;

    typedef struct {
        count_t long_press;
        count_t first_delay;
        count_t rate_step;
        count_t pause;
    } reg_set_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    key_req_t    key_requests[$];
    key_result_t expected_events[$];

    logic [HB-1:0] key_hist [KEY_COUNT_DEF];
    count_t        key_cnt  [KEY_COUNT_DEF];
    mode_t         key_mode [KEY_COUNT_DEF];
    count_t        cfg_mirror [4];

    bit       want_down [KEY_COUNT_DEF];
    int       focus_keys [3];
    reg_set_t phase_regs [PHASES];

    key_req_t on_bus;
    int       send_gap = 0;
    int       send_quiet = 0;
    int       stall_left = 0;
    int       recv_quiet = 0;
    int       idle_cycles = 0;
    int       errors = 0;
    int       results_checked = 0;
    int       event_seen [5];

    key_debounce_autorepeat_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Updates the key state for one request and returns the event it raises.
    function automatic key_result_t next_key_event(key_req_t rq);
        key_result_t  res;
        logic [HB-1:0] h;
        count_t       c;
        mode_t        m;
        event_t       ev;
        int           k;
        k = int'(rq.key);
        ev = EV_NONE;
        if (rq.op == OP_TICK) begin
            h = {key_hist[k][HB-2:0], rq.level};
            c = key_cnt[k] + 8'd1;
            m = key_mode[k];
            key_hist[k] = h;
            if (m != MODE_OFF && h == '0) begin
                if (m != MODE_KILLED)
                    ev = EV_RELEASE;
                c = '0;
                m = MODE_OFF;
            end
            case (m) inside
                MODE_OFF: begin
                    if (h == HIST_FULL) begin
                        m = MODE_START;
                        c = '0;
                    end
                end
                MODE_START: begin
                    ev = EV_FIRST;
                    m = MODE_DELAY;
                    c = '0;
                end
                MODE_DELAY: begin
                    if (c == cfg_mirror[CFG_LONG_PRESS])
                        ev = EV_LONG;
                    if (c == cfg_mirror[CFG_FIRST_DELAY]) begin
                        m = MODE_P16;
                        c = '0;
                    end
                end
                MODE_P16, MODE_P8, MODE_P4, MODE_P2, MODE_P1: begin
                    if (m != MODE_P1 && c >= cfg_mirror[CFG_RATE_STEP]) begin
                        m = m >> 1;
                        c = '0;
                    end
                    if ((c & count_t'(m - 7'd1)) == '0)
                        ev = EV_REPEAT;
                end
                MODE_PAUSE: begin
                    if (c >= cfg_mirror[CFG_PAUSE]) begin
                        m = MODE_P8;
                        c = '0;
                    end
                end
                default: ;
            endcase
            key_cnt[k] = c;
            key_mode[k] = m;
        end else if (rq.op == OP_PAUSE) begin
            key_mode[k] = MODE_PAUSE;
            key_cnt[k] = '0;
        end else if (rq.op == OP_KILL) begin
            key_mode[k] = MODE_KILLED;
        end
        res.key_id = rq.key;
        res.event_res = ev;
        res.pressed = (key_hist[k] == HIST_FULL);
        return res;
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_req(op_t op, int key, bit level);
        key_req_t rq;
        rq.op = op;
        rq.key = key[KEY_W-1:0];
        rq.level = level;
        key_requests.push_back(rq);
    endtask

    // Mostly held and released keys on a few busy keys, with bounce noise,
    // pause, kill and spare requests mixed in.
    task automatic queue_key_traffic(int count);
        int  key;
        int  r;
        bit  level;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7)
                key = focus_keys[$urandom_range(0, 2)];
            else
                key = $urandom_range(0, KEY_COUNT_DEF - 1);
            r = $urandom_range(0, 99);
            level = 1'($urandom_range(0, 1));
            if (r < 4) begin
                push_req(OP_PAUSE, key, level);
            end else if (r < 7) begin
                push_req(OP_KILL, key, level);
            end else if (r < 9) begin
                push_req(OP_SPARE, key, level);
            end else begin
                if (want_down[key] && $urandom_range(0, 59) == 0)
                    want_down[key] = 1'b0;
                else if (!want_down[key] && $urandom_range(0, 9) == 0)
                    want_down[key] = 1'b1;
                level = want_down[key] ^ ($urandom_range(0, 24) == 0);
                push_req(OP_TICK, key, level);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (key_requests.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, count_t val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_mirror[idx] = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_events.push_back(next_key_event(on_bus));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (key_requests.size() > 0) begin
                    on_bus = key_requests.pop_front();
                    s_tdata <= {3'b000, on_bus.level, on_bus.key};
                    s_tuser <= on_bus.op;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge aclk) begin
        key_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (m_tdata[6:4] < 5)
                    event_seen[m_tdata[6:4]]++;
                if (expected_events.size() == 0) begin
                    errors++;
                    $error("result with no request pending: tdata %h", m_tdata);
                end else begin
                    want = expected_events.pop_front();
                    if (m_tdata[3:0] !== want.key_id) begin
                        errors++;
                        $error("key_id expected %0d actual %0d", want.key_id, m_tdata[3:0]);
                    end
                    if (m_tdata[6:4] !== want.event_res) begin
                        errors++;
                        $error("event_res expected %0d actual %0d",
                               want.event_res, m_tdata[6:4]);
                    end
                    if (m_tdata[7] !== want.pressed) begin
                        errors++;
                        $error("pressed expected %0d actual %0d", want.pressed, m_tdata[7]);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(recv_quiet);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no progress for %0d cycles.", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < KEY_COUNT_DEF; k++) begin
            key_hist[k] = '0;
            key_cnt[k] = '0;
            key_mode[k] = MODE_OFF;
            want_down[k] = 1'b0;
        end
        for (int e = 0; e < 5; e++)
            event_seen[e] = 0;
        cfg_mirror[CFG_LONG_PRESS] = LONG_PRESS_RST;
        cfg_mirror[CFG_FIRST_DELAY] = FIRST_DELAY_RST;
        cfg_mirror[CFG_RATE_STEP] = RATE_STEP_RST;
        cfg_mirror[CFG_PAUSE] = PAUSE_RST;

        phase_regs[0] = '{8'd1, 8'd1, 8'd1, 8'd1};
        phase_regs[1] = '{8'd255, 8'd255, 8'd255, 8'd255};
        phase_regs[2] = '{8'd3, 8'd6, 8'd2, 8'd5};
        phase_regs[3] = '{8'd0, 8'd0, 8'd0, 8'd0};
        phase_regs[4] = '{count_t'($urandom_range(1, 12)), count_t'($urandom_range(1, 12)),
                          count_t'($urandom_range(1, 12)), count_t'($urandom_range(1, 12))};
        phase_regs[5] = '{LONG_PRESS_RST, FIRST_DELAY_RST, RATE_STEP_RST, PAUSE_RST};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening with the reset register values.
        for (int i = 0; i < 5; i++)
            push_req(OP_TICK, 0, 1'b1);
        push_req(OP_KILL, 0, 1'b1);
        for (int i = 0; i < 4; i++)
            push_req(OP_TICK, 0, 1'b0);
        push_req(OP_PAUSE, 1, 1'b0);
        push_req(OP_TICK, 1, 1'b0);
        push_req(OP_SPARE, 2, 1'b1);
        push_req(OP_SPARE, 15, 1'b0);
        for (int i = 0; i < 5; i++)
            push_req(OP_TICK, 15, 1'b1);
        push_req(OP_PAUSE, 15, 1'b1);
        push_req(OP_TICK, 15, 1'b1);
        push_req(OP_TICK, 3, 1'b1);
        push_req(OP_TICK, 3, 1'b1);
        push_req(OP_TICK, 3, 1'b0);
        push_req(OP_TICK, 3, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_reg(CFG_LONG_PRESS, phase_regs[p].long_press);
            write_reg(CFG_FIRST_DELAY, phase_regs[p].first_delay);
            write_reg(CFG_RATE_STEP, phase_regs[p].rate_step);
            write_reg(CFG_PAUSE, phase_regs[p].pause);
            for (int f = 0; f < 3; f++)
                focus_keys[f] = $urandom_range(0, KEY_COUNT_DEF - 1);
            if (p == 2) begin
                // Let the block drain completely in the middle of the phase.
                queue_key_traffic(PHASE_REQ / 2);
                wait_idle();
                queue_key_traffic(PHASE_REQ - PHASE_REQ / 2);
            end else begin
                queue_key_traffic(PHASE_REQ);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d results over %0d register settings plus reset values.",
                 results_checked, PHASES);
        $display("Events seen: %0d first press, %0d repeat, %0d long press, %0d release.",
                 event_seen[EV_FIRST], event_seen[EV_REPEAT], event_seen[EV_LONG],
                 event_seen[EV_RELEASE]);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/kdar_pkg.sv
hw/rtl/kdar_ram.sv
hw/rtl/key_debounce_autorepeat_top.sv
tb/tb.sv
